FILE: src/heightmap_vertex_normal_top_macros.svh
// Assertion macros for the heightmap vertex normal block.
// Included by heightmap_vertex_normal_top; no other dependencies.
`ifndef HEIGHTMAP_VERTEX_NORMAL_TOP_MACROS_SVH
`define HEIGHTMAP_VERTEX_NORMAL_TOP_MACROS_SVH

// same-cycle implication
`define HVN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HVN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/hvn_pkg.sv
// Shared types and constants for the heightmap vertex normal block.
// No dependencies; used by hvn_cs_unit, the top level and the testbench.
package hvn_pkg;

   // configuration register indexes and reset values
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL     = 2'd2;
   localparam logic [8:0] GRID_COLS_RST = 9'd256;
   localparam logic [8:0] GRID_ROWS_RST = 9'd256;
   localparam logic [7:0] LEVEL_RST     = 8'd15;

   // command and status codes
   localparam logic CMD_WRITE      = 1'b0;
   localparam logic CMD_QUERY      = 1'b1;
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_OUTSIDE = 1'b1;

   // datapath widths: four faces of 8-bit heights and 8-bit level
   localparam int SX_W  = 11;   // signed sum of a-b or a-c
   localparam int SY_W  = 10;   // sum of level
   localparam int MAG_W = 10;
   localparam int SQ_W  = 20;
   localparam int SUM_W = 22;   // sum of three squares
   localparam int REM_W = 24;
   localparam int QUO_W = 29;   // quotient mag^2 * 2^28 / sumsq
   localparam int SRC_W = 30;
   localparam int Q_W   = 15;   // Q1.14 magnitude
   localparam int CNT_W = 5;

   // shared unit
   localparam logic [CNT_W-1:0] DIV_STEPS  = 5'd29;
   localparam logic [CNT_W-1:0] SQRT_STEPS = 5'd15;
   localparam logic MODE_DIV  = 1'b0;
   localparam logic MODE_SQRT = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] col;
      logic [7:0] row;
      logic [7:0] height;
   } req_word_type;

   typedef struct packed {
      logic               status;
      logic signed [15:0] normal_x;
      logic [14:0]        normal_y;
      logic signed [15:0] normal_z;
   } rsp_word_type;

   typedef struct packed {
      logic start;
      logic mode;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

FILE: src/hvn_cs_unit.sv
// Shared compare-subtract unit: restoring divide and digit-by-digit square root.
// Depends on hvn_pkg.
module hvn_cs_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  hvn_pkg::unit_cmd_type       cmd,
   input  logic [hvn_pkg::SQ_W-1:0]    dividend_hi,
   input  logic [hvn_pkg::SUM_W-1:0]   divisor,
   input  logic [hvn_pkg::QUO_W-1:0]   radicand,
   output hvn_pkg::unit_stat_type      stat,
   output logic [hvn_pkg::QUO_W-1:0]   result
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic                        mode_ff, mode_in;
   logic [hvn_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [hvn_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic [hvn_pkg::SUM_W-1:0]   den_ff, den_in;
   logic [hvn_pkg::SRC_W-1:0]   src_ff, src_in;
   logic [hvn_pkg::QUO_W-1:0]   quo_ff, quo_in;

   logic [hvn_pkg::REM_W-1:0]   rem_sh;
   logic [hvn_pkg::REM_W-1:0]   trial;
   logic [hvn_pkg::REM_W-1:0]   op_a;
   logic [hvn_pkg::REM_W-1:0]   op_b;
   logic [hvn_pkg::REM_W:0]     diff;
   logic                        ge;
   logic [hvn_pkg::REM_W-1:0]   kept;

   // one subtractor serves both modes
   always_comb begin
      rem_sh = {rem_ff[hvn_pkg::REM_W-3:0], src_ff[hvn_pkg::SRC_W-1 -: 2]};
      trial  = {quo_ff[hvn_pkg::REM_W-3:0], 2'b01};
      op_a   = (mode_ff == hvn_pkg::MODE_SQRT) ? rem_sh : rem_ff;
      op_b   = (mode_ff == hvn_pkg::MODE_SQRT) ? trial : hvn_pkg::REM_W'(den_ff);
      diff   = {1'b0, op_a} - {1'b0, op_b};
      ge     = !diff[hvn_pkg::REM_W];
      kept   = ge ? diff[hvn_pkg::REM_W-1:0] : op_a;
   end

   // step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      src_in  = src_ff;
      quo_in  = quo_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         mode_in = cmd.mode;
         quo_in  = '0;
         den_in  = divisor;
         if (cmd.mode == hvn_pkg::MODE_DIV) begin
            cnt_in = hvn_pkg::DIV_STEPS;
            rem_in = hvn_pkg::REM_W'(dividend_hi);
            src_in = '0;
         end else begin
            cnt_in = hvn_pkg::SQRT_STEPS;
            rem_in = '0;
            src_in = hvn_pkg::SRC_W'(radicand);
         end
      end else if (busy_ff) begin
         quo_in = {quo_ff[hvn_pkg::QUO_W-2:0], ge};
         if (mode_ff == hvn_pkg::MODE_SQRT) begin
            rem_in = kept;
            src_in = {src_ff[hvn_pkg::SRC_W-3:0], 2'b00};
         end else begin
            // low dividend bits are all zero
            rem_in = {kept[hvn_pkg::REM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == hvn_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      src_ff  <= src_in;
      quo_ff  <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = quo_ff;

endmodule

FILE: src/hvn_store.sv
// Height sample memory with a clearing sweep after reset.
// Depends on nothing but its parameters.
module hvn_store #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data,
   output logic          clr_busy
);

   logic [7:0]    mem [DEPTH];
   logic [7:0]    rd_data_ff;
   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [7:0]    mem_wd;

   // sweep one entry per cycle until the last address
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // write port shared by the sweep and the sequencer
   assign mem_we = clr_busy_ff | wr_en;
   assign mem_wa = clr_busy_ff ? clr_addr_ff : wr_addr;
   assign mem_wd = clr_busy_ff ? 8'd0 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

FILE: src/heightmap_vertex_normal_top.sv
// Heightmap vertex normal block: top level, sequencer and accumulators.
// Depends on hvn_pkg, hvn_store, hvn_cs_unit and the assertion macro header.
//
// Usage:
//  - Request words (req_valid/req_stall/req_word) carry cmd, col, row, height.
//    cmd write stores a height; cmd query returns the averaged unit normal.
//  - Every request gives exactly one response word on rsp_valid/rsp_stall.
//  - One request is worked at a time; req_stall is low only when idle.
//    A query takes 12 store read slots, 3 squaring steps, then per component
//    a 29-step divide and a 15-step square root on the one shared unit; when
//    the summed normal is zero it skips the divide and root. The response
//    word appears in the same cycle as the next request can be accepted.
//  - The response sits in an output register. While rsp_stall is high it
//    holds, and the next request is already accepted into the sequencer.
//  - Reset sets the configuration registers and starts a sweep that zeroes
//    all MAX_COLS*MAX_ROWS entries of the height memory (65536 by default),
//    with req_stall high. Configuration writes are taken at any time.
//  - csr_wr_en/csr_index/csr_wr_data write grid_cols, grid_rows, level.
`include "heightmap_vertex_normal_top_macros.svh"
module heightmap_vertex_normal_top #(
   parameter int MAX_COLS = 256,
   parameter int MAX_ROWS = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  hvn_pkg::req_word_type            req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output hvn_pkg::rsp_word_type            rsp_word,
   input  logic                             csr_wr_en,
   input  logic [hvn_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hvn_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_COLS + 1);
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int CEW   = CW + 8;
   localparam int REW   = RW + 8;

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_BASE   = 4'd2;
   localparam logic [3:0] ST_WRITE  = 4'd3;
   localparam logic [3:0] ST_READ   = 4'd4;
   localparam logic [3:0] ST_DRAIN  = 4'd5;
   localparam logic [3:0] ST_SQUARE = 4'd6;
   localparam logic [3:0] ST_CHECK  = 4'd7;
   localparam logic [3:0] ST_DIV    = 4'd8;
   localparam logic [3:0] ST_SQRT   = 4'd9;
   localparam logic [3:0] ST_OUT    = 4'd10;

   // corner of a face: lower-left, right, upper
   localparam logic [1:0] PT_A = 2'd0;
   localparam logic [1:0] PT_B = 2'd1;
   localparam logic [1:0] PT_C = 2'd2;
   localparam logic [1:0] FACE_LAST = 2'd3;

   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   // configuration
   logic [8:0] grid_cols_ff;
   logic [8:0] grid_rows_ff;
   logic [7:0] level_ff;

   logic [3:0]                    state_ff, state_in;
   hvn_pkg::req_word_type         req_ff, req_in;
   logic [AW-1:0]                 base_ff, base_in;
   logic                          status_ff, status_in;
   logic [1:0]                    face_ff, face_in;
   logic [1:0]                    pt_ff, pt_in;
   logic [1:0]                    comp_ff, comp_in;
   logic                          tag_valid_ff, tag_valid_in;
   logic [1:0]                    tag_pt_ff, tag_pt_in;
   logic [7:0]                    a_ff, a_in;
   logic signed [hvn_pkg::SX_W-1:0] sx_ff, sx_in;
   logic signed [hvn_pkg::SX_W-1:0] sz_ff, sz_in;
   logic [hvn_pkg::SY_W-1:0]      sy_ff, sy_in;
   logic [hvn_pkg::SUM_W-1:0]     sumsq_ff, sumsq_in;
   logic [hvn_pkg::Q_W-1:0]       qx_ff, qx_in;
   logic [hvn_pkg::Q_W-1:0]       qy_ff, qy_in;
   logic [hvn_pkg::Q_W-1:0]       qz_ff, qz_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   hvn_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;

   logic [CW-1:0]                 ec;
   logic [RW-1:0]                 er;
   logic                          outside;
   logic [CEW-1:0]                base_prod;
   logic                          fx_ok, fy_ok, face_ok;
   logic                          x_neg, x_pos, y_neg, y_pos;
   logic [AW-1:0]                 row_term, col_term, rd_addr;
   logic                          rd_en, wr_en;
   logic [7:0]                    rd_data;
   logic                          clr_busy;
   logic signed [8:0]             d_ab, d_ac;
   logic [hvn_pkg::MAG_W-1:0]     mag_sel;
   logic [hvn_pkg::SQ_W-1:0]      mag_sq;
   logic [15:0]                   qx_ext, qz_ext;
   hvn_pkg::unit_cmd_type         unit_cmd;
   hvn_pkg::unit_stat_type        unit_stat;
   logic [hvn_pkg::QUO_W-1:0]     unit_result;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= hvn_pkg::GRID_COLS_RST;
         grid_rows_ff <= hvn_pkg::GRID_ROWS_RST;
         level_ff     <= hvn_pkg::LEVEL_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            hvn_pkg::CSR_GRID_COLS: grid_cols_ff <= csr_wr_data;
            hvn_pkg::CSR_GRID_ROWS: grid_rows_ff <= csr_wr_data;
            hvn_pkg::CSR_LEVEL:     level_ff     <= csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   // grid size saturated to the store
   assign ec = (int'(grid_cols_ff) > MAX_COLS) ? CW'(MAX_COLS) : CW'(grid_cols_ff);
   assign er = (int'(grid_rows_ff) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(grid_rows_ff);

   assign outside = (CEW'(req_ff.col) >= CEW'(ec)) || (REW'(req_ff.row) >= REW'(er));
   assign base_prod = CEW'(req_ff.row) * CEW'(ec) + CEW'(req_ff.col);

   // face bit 0 set: face to the right of the vertex; bit 1 set: face above
   assign fx_ok = face_ff[0] ? (CEW'(req_ff.col) + CEW'(1) < CEW'(ec))
                             : (req_ff.col != 8'd0);
   assign fy_ok = face_ff[1] ? (REW'(req_ff.row) + REW'(1) < REW'(er))
                             : (req_ff.row != 8'd0);
   assign face_ok = fx_ok && fy_ok;

   // neighbor address relative to the vertex
   assign x_neg = !face_ff[0] && (pt_ff != PT_B);
   assign x_pos =  face_ff[0] && (pt_ff == PT_B);
   assign y_neg = !face_ff[1] && (pt_ff != PT_C);
   assign y_pos =  face_ff[1] && (pt_ff == PT_C);
   assign row_term = y_pos ? AW'(ec) : (y_neg ? (AW'(0) - AW'(ec)) : AW'(0));
   assign col_term = x_pos ? AW'(1)  : (x_neg ? (AW'(0) - AW'(1))  : AW'(0));
   assign rd_addr  = base_ff + row_term + col_term;

   assign d_ab = $signed({1'b0, a_ff}) - $signed({1'b0, rd_data});
   assign d_ac = d_ab;

   // magnitude of the component being worked
   always_comb begin
      case (comp_ff)
         COMP_X:  mag_sel = sx_ff[hvn_pkg::SX_W-1] ? hvn_pkg::MAG_W'(-sx_ff)
                                                   : hvn_pkg::MAG_W'(sx_ff);
         COMP_Y:  mag_sel = hvn_pkg::MAG_W'(sy_ff);
         COMP_Z:  mag_sel = sz_ff[hvn_pkg::SX_W-1] ? hvn_pkg::MAG_W'(-sz_ff)
                                                   : hvn_pkg::MAG_W'(sz_ff);
         default: mag_sel = '0;
      endcase
   end
   assign mag_sq = hvn_pkg::SQ_W'(mag_sel) * hvn_pkg::SQ_W'(mag_sel);

   assign qx_ext = {1'b0, qx_ff};
   assign qz_ext = {1'b0, qz_ff};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      base_in      = base_ff;
      status_in    = status_ff;
      face_in      = face_ff;
      pt_in        = pt_ff;
      comp_in      = comp_ff;
      tag_valid_in = 1'b0;
      tag_pt_in    = pt_ff;
      a_in         = a_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sz_in        = sz_ff;
      sumsq_in     = sumsq_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      qz_in        = qz_ff;
      unit_cmd     = '0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;

      // read data lands in the cycle after its address
      if (tag_valid_ff) begin
         case (tag_pt_ff)
            PT_A: a_in = rd_data;
            PT_B: sx_in = sx_ff + hvn_pkg::SX_W'(d_ab);
            PT_C: begin
               sz_in = sz_ff + hvn_pkg::SX_W'(d_ac);
               sy_in = sy_ff + hvn_pkg::SY_W'(level_ff);
            end
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            if (!clr_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_word;
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            base_in  = AW'(base_prod);
            sx_in    = '0;
            sy_in    = '0;
            sz_in    = '0;
            sumsq_in = '0;
            qx_in    = '0;
            qy_in    = '0;
            qz_in    = '0;
            face_in  = '0;
            pt_in    = PT_A;
            comp_in  = COMP_X;
            if (outside) begin
               status_in = hvn_pkg::STATUS_OUTSIDE;
               state_in  = ST_OUT;
            end else begin
               status_in = hvn_pkg::STATUS_OK;
               if (req_ff.cmd == hvn_pkg::CMD_QUERY) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            wr_en    = 1'b1;
            state_in = ST_OUT;
         end
         ST_READ: begin
            rd_en        = face_ok;
            tag_valid_in = face_ok;
            if (pt_ff == PT_C) begin
               pt_in   = PT_A;
               face_in = face_ff + 1'b1;
               if (face_ff == FACE_LAST) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               pt_in = pt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            sumsq_in = sumsq_ff + hvn_pkg::SUM_W'(mag_sq);
            if (comp_ff == COMP_Z) begin
               comp_in  = COMP_X;
               state_in = ST_CHECK;
            end else begin
               comp_in = comp_ff + 1'b1;
            end
         end
         ST_CHECK: begin
            if (sumsq_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               unit_cmd.start = 1'b1;
               unit_cmd.mode  = hvn_pkg::MODE_DIV;
               state_in       = ST_DIV;
            end
         end
         ST_DIV: begin
            if (unit_stat.done) begin
               unit_cmd.start = 1'b1;
               unit_cmd.mode  = hvn_pkg::MODE_SQRT;
               state_in       = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (unit_stat.done) begin
               case (comp_ff)
                  COMP_X:  qx_in = unit_result[hvn_pkg::Q_W-1:0];
                  COMP_Y:  qy_in = unit_result[hvn_pkg::Q_W-1:0];
                  default: qz_in = unit_result[hvn_pkg::Q_W-1:0];
               endcase
               if (comp_ff == COMP_Z) begin
                  state_in = ST_OUT;
               end else begin
                  comp_in  = comp_ff + 1'b1;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_word_in.status   = status_ff;
               rsp_word_in.normal_x = sx_ff[hvn_pkg::SX_W-1] ? (16'd0 - qx_ext) : qx_ext;
               rsp_word_in.normal_y = qy_ff;
               rsp_word_in.normal_z = sz_ff[hvn_pkg::SX_W-1] ? (16'd0 - qz_ext) : qz_ext;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         tag_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tag_valid_ff <= tag_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      base_ff     <= base_in;
      status_ff   <= status_in;
      face_ff     <= face_in;
      pt_ff       <= pt_in;
      comp_ff     <= comp_in;
      tag_pt_ff   <= tag_pt_in;
      a_ff        <= a_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      sz_ff       <= sz_in;
      sumsq_ff    <= sumsq_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      qz_ff       <= qz_in;
      rsp_word_ff <= rsp_word_in;
   end

   hvn_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (base_ff),
      .wr_data  (req_ff.height),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .clr_busy (clr_busy)
   );

   hvn_cs_unit u_unit (
      .clock       (clock),
      .reset       (reset),
      .cmd         (unit_cmd),
      .dividend_hi (mag_sq),
      .divisor     (sumsq_ff),
      .radicand    (unit_result),
      .stat        (unit_stat),
      .result      (unit_result)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // checks
   `HVN_ASSERT_NOW(a_clear_holds_req, clock, reset, clr_busy, req_stall, "word taken during memory clear")
   `HVN_ASSERT_NOW(a_unit_start_idle, clock, reset, unit_cmd.start, !unit_stat.busy, "shared unit restarted while busy")
   `HVN_ASSERT_NEXT(a_unit_runs, clock, reset, unit_cmd.start, unit_stat.busy, "shared unit did not start")
   `HVN_ASSERT_NOW(a_outside_zero, clock, reset, rsp_valid_ff && (rsp_word_ff.status == hvn_pkg::STATUS_OUTSIDE), (rsp_word_ff.normal_x == 16'sd0) && (rsp_word_ff.normal_y == 15'd0) && (rsp_word_ff.normal_z == 16'sd0), "outside-grid word with nonzero normal")
   `HVN_ASSERT_NOW(a_unit_bound, clock, reset, rsp_valid_ff, rsp_word_ff.normal_y <= 15'd16384, "vertical component above one")

endmodule

FILE: sim/heightmap_vertex_normal_top_tb.sv
// Self-checking testbench for heightmap_vertex_normal_top: height writes and
// averaged vertex normal queries checked against an in-bench predictor.
// Depends on hvn_pkg and the heightmap_vertex_normal_top RTL.
module heightmap_vertex_normal_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hvn_pkg::*;

   localparam int DIM_MAX = 256;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_word_type         req_word;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_word_type         rsp_word;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   // predictor state
   bit [7:0]     hmap [DIM_MAX*DIM_MAX];
   int unsigned  cfg_cols, cfg_rows, cfg_level;

   req_word_type pend_q [$];
   rsp_word_type normal_q [$];
   int           err_cnt;
   int           send_idle_pct, stall_pct;
   bit           pressure_on;
   int           hold_left;

   heightmap_vertex_normal_top uut (.*);

   // clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      err_cnt++;
   endtask

   // largest q with q*sqrt(sumsq) <= 16384*mag
   function automatic logic [14:0] unit_q(longint unsigned mag, longint unsigned sumsq);
      longint unsigned target, t;
      logic [14:0]     q;
      target = (mag * mag) << 28;
      q = '0;
      for (int b = 14; b >= 0; b--) begin
         t = longint'(q | (15'd1 << b));
         if (t * t * sumsq <= target) q = t[14:0];
      end
      return q;
   endfunction

   function automatic logic signed [15:0] signed_unit(int s, longint unsigned sumsq);
      logic [15:0] q;
      q = {1'b0, unit_q(s < 0 ? -s : s, sumsq)};
      return s < 0 ? -q : q;
   endfunction

   // apply one request word to the model, return the expected response
   function automatic rsp_word_type predict_normal(req_word_type w);
      rsp_word_type    r;
      int unsigned     ec, er, fx, fy;
      int              sx, sy, sz, a, b, c;
      longint unsigned sumsq;
      r = '0;
      r.status = STATUS_OK;
      ec = cfg_cols > DIM_MAX ? DIM_MAX : cfg_cols;
      er = cfg_rows > DIM_MAX ? DIM_MAX : cfg_rows;
      if (w.col >= ec || w.row >= er) begin
         r.status = STATUS_OUTSIDE;
         return r;
      end
      if (w.cmd == CMD_WRITE) begin
         hmap[w.row * ec + w.col] = w.height;
         return r;
      end
      sx = 0;
      sy = 0;
      sz = 0;
      for (int dy = -1; dy <= 0; dy++) begin
         for (int dx = -1; dx <= 0; dx++) begin
            if (int'(w.col) + dx >= 0 && int'(w.row) + dy >= 0) begin
               fx = w.col + dx;
               fy = w.row + dy;
               if (fx + 1 < ec && fy + 1 < er) begin
                  a = hmap[fy * ec + fx];
                  b = hmap[fy * ec + fx + 1];
                  c = hmap[(fy + 1) * ec + fx];
                  sx += a - b;
                  sy += cfg_level;
                  sz += a - c;
               end
            end
         end
      end
      sumsq = longint'(sx * sx) + longint'(sy * sy) + longint'(sz * sz);
      if (sumsq == 0) return r;
      r.normal_x = signed_unit(sx, sumsq);
      r.normal_y = unit_q(sy, sumsq);
      r.normal_z = signed_unit(sz, sumsq);
      return r;
   endfunction

   // driver: present queued words, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_word  <= '0;
      end else begin
         if (req_valid && !req_stall) normal_q.push_back(predict_normal(req_word));
         if (!req_valid || !req_stall) begin
            if (pend_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_word  <= pend_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off counter
   always @(posedge clock) begin
      if (!pressure_on) hold_left <= 2000;
      else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // monitor: compare each response word with the oldest expectation
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (normal_q.size() == 0) begin
               report("response word with nothing expected");
            end else begin
               exp_w = normal_q.pop_front();
               if (rsp_word.status !== exp_w.status)
                  report($sformatf("status %0b exp %0b", rsp_word.status, exp_w.status));
               if (rsp_word.normal_x !== exp_w.normal_x)
                  report($sformatf("normal_x %0d exp %0d", rsp_word.normal_x, exp_w.normal_x));
               if (rsp_word.normal_y !== exp_w.normal_y)
                  report($sformatf("normal_y %0d exp %0d", rsp_word.normal_y, exp_w.normal_y));
               if (rsp_word.normal_z !== exp_w.normal_z)
                  report($sformatf("normal_z %0d exp %0d", rsp_word.normal_z, exp_w.normal_z));
            end
         end
         rsp_stall <= (pressure_on && hold_left > 1) || ($urandom_range(99) < stall_pct);
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val[CSR_DATA_W-1:0];
      if (idx == CSR_GRID_COLS) cfg_cols = val & 32'h1FF;
      else if (idx == CSR_GRID_ROWS) cfg_rows = val & 32'h1FF;
      else if (idx == CSR_LEVEL) cfg_level = val & 32'hFF;
   endtask

   task automatic set_grid(int unsigned cols, int unsigned rows, int unsigned lvl);
      csr_write(CSR_GRID_COLS, cols);
      csr_write(CSR_GRID_ROWS, rows);
      csr_write(CSR_LEVEL, lvl);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_word(logic cmd, int unsigned col, int unsigned row, int unsigned h);
      req_word_type w;
      w.cmd    = cmd;
      w.col    = col[7:0];
      w.row    = row[7:0];
      w.height = h[7:0];
      pend_q.push_back(w);
   endtask

   // wait until every word is accepted and answered, then let the block settle
   task automatic drain();
      while (pend_q.size() > 0 || req_valid || normal_q.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // mostly in-grid random words with random heights, some anywhere
   task automatic random_words(int n);
      int unsigned ec, er, h;
      ec = cfg_cols > DIM_MAX ? DIM_MAX : cfg_cols;
      er = cfg_rows > DIM_MAX ? DIM_MAX : cfg_rows;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: h = 0;
            1: h = 255;
            default: h = $urandom_range(255);
         endcase
         if ($urandom_range(9) == 0 || ec == 0 || er == 0)
            push_word($urandom_range(1), $urandom_range(255), $urandom_range(255), h);
         else
            push_word($urandom_range(1), $urandom_range(ec - 1), $urandom_range(er - 1), h);
      end
   endtask

   initial begin
      err_cnt       = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      pressure_on   = 1'b0;
      cfg_cols      = GRID_COLS_RST;
      cfg_rows      = GRID_ROWS_RST;
      cfg_level     = LEVEL_RST;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_word      = '0;
      rsp_stall     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wr_data   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset grid, corners and extremes
      push_word(CMD_WRITE, 0, 0, 255);
      push_word(CMD_WRITE, 1, 0, 0);
      push_word(CMD_WRITE, 0, 1, 128);
      push_word(CMD_WRITE, 255, 255, 255);
      push_word(CMD_WRITE, 254, 255, 1);
      push_word(CMD_QUERY, 0, 0, 255);
      push_word(CMD_QUERY, 1, 1, 0);
      push_word(CMD_QUERY, 255, 255, 0);
      push_word(CMD_QUERY, 255, 0, 0);
      push_word(CMD_QUERY, 0, 255, 0);
      push_word(CMD_QUERY, 254, 254, 0);
      drain();

      // oversized grid saturates; level zero on flat and on written terrain
      set_grid(511, 300, 0);
      push_word(CMD_QUERY, 200, 200, 0);
      push_word(CMD_QUERY, 0, 0, 0);
      push_word(CMD_QUERY, 1, 0, 0);
      push_word(CMD_WRITE, 250, 250, 0);
      drain();

      // smallest grid with a face, outside on each axis
      set_grid(2, 2, 1);
      push_word(CMD_WRITE, 2, 0, 9);
      push_word(CMD_QUERY, 0, 2, 0);
      push_word(CMD_WRITE, 1, 1, 200);
      push_word(CMD_QUERY, 0, 0, 0);
      push_word(CMD_QUERY, 1, 1, 0);
      drain();

      // single column has no faces; empty grid is all outside
      set_grid(1, 3, 15);
      push_word(CMD_QUERY, 0, 1, 0);
      push_word(CMD_WRITE, 0, 2, 77);
      drain();
      set_grid(0, 0, 15);
      push_word(CMD_QUERY, 0, 0, 0);
      drain();

      // random phases over several grids and idling mixes
      set_grid(256, 256, 255);
      random_words(300);
      drain();

      set_grid(16, 9, 15);
      send_idle_pct = 51;
      random_words(300);
      drain();

      set_grid(5, 37, 1);
      send_idle_pct = 0;
      stall_pct     = 51;
      random_words(300);
      drain();

      set_grid(3, 3, 200);
      send_idle_pct = 14;
      stall_pct     = 14;
      random_words(300);
      drain();

      // receiver holds off while words keep coming
      set_grid(64, 64, 8);
      send_idle_pct = 0;
      stall_pct     = 0;
      pressure_on   = 1'b1;
      random_words(300);
      drain();
      pressure_on = 1'b0;

      if (err_cnt == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // run limit
   initial begin
      #50_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: heightmap_vertex_normal_top.f
+incdir+src
src/hvn_pkg.sv
src/hvn_cs_unit.sv
src/hvn_store.sv
src/heightmap_vertex_normal_top.sv
sim/heightmap_vertex_normal_top_tb.sv
